// File: src/sprite_rle_decoder_defines.svh
// Assertion macros shared by the sprite decoder RTL.
`ifndef SPRITE_RLE_DECODER_DEFINES_SVH
`define SPRITE_RLE_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite decoder check failed");

// Next-cycle implication, checked out of reset.
`define SRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite decoder check failed");

`endif

// File: src/srd_pkg.sv
// Types and constants of the sprite run-length decoder.
package srd_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ALPHA   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_SIDE = 1'd1;
  localparam logic [CFG_DATA_W-1:0] SIDE_RESET     = 7'd32;

  // Result field widths
  localparam int IDX_W = 13;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_SKIP  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // End status codes
  localparam logic [2:0] ST_COMPLETE   = 3'd0;
  localparam logic [2:0] ST_CAP_FULL   = 3'd1;
  localparam logic [2:0] ST_SHORT_HDR  = 3'd2;
  localparam logic [2:0] ST_SKIP_OVF   = 3'd3;
  localparam logic [2:0] ST_COLOR_OVF  = 3'd4;
  localparam logic [2:0] ST_DATA_SHORT = 3'd5;

  // Result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Decoder phase
  typedef enum logic [3:0] {
    PH_DONE,
    PH_KEY,
    PH_SIZE_LO,
    PH_SIZE_HI,
    PH_T_LO,
    PH_T_HI,
    PH_C_LO,
    PH_C_HI,
    PH_PIX
  } phase_t;

  typedef struct packed {
    logic       record_start;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] pixel_index;
    logic [15:0]      skip_count;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [2:0]       status;
    logic             last;
  } out_item_t;

endpackage

// File: src/sprite_rle_decoder.sv
// Sprite run-length decoder: byte-serial record parser with a small result queue.
//
// Input channel (in_valid/in_ready/in_data) takes one record byte per item;
// record_start marks the first key byte of a record. Each byte is decoded in
// the cycle it is accepted and its results (zero, one or two) are written to
// a 4-entry result queue; the first result is offered on out_valid once it
// reaches the queue head. Result channel (out_valid/out_ready/out_data)
// gives skip, pixel and end items in record order.
// Throughput: one byte per cycle while in_ready is high. in_ready is high while
// the queue has room for two results, so a stalled receiver back-pressures
// the input within a couple of items and nothing is dropped. A byte that
// yields two results needs two reads on the output; the queue absorbs that.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes use_alpha (index 0) and
// sprite_side (index 1); capacity is side squared, side clamped to 1..MAX_SIDE.
// Reset (rst_n low, synchronous) empties the queue, returns to the idle phase
// (bytes ignored until record_start) and restores use_alpha=0, side=32.
module sprite_rle_decoder #(
  parameter int MAX_SIDE = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  srd_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output srd_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [srd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

`include "sprite_rle_decoder_defines.svh"

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CS_W   = (SIDE_W > srd_pkg::CFG_DATA_W) ? SIDE_W : srd_pkg::CFG_DATA_W;
  localparam int PIX_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int CMP_W  = (PIX_W > 16) ? PIX_W : 16;

  // Registers
  logic                            use_alpha_r;
  logic [srd_pkg::CFG_DATA_W-1:0]  sprite_side_r;
  srd_pkg::phase_t                 phase_r, phase_nxt;
  logic [1:0]                      header_count_r, header_count_nxt;
  logic [15:0]                     payload_size_r, payload_size_nxt;
  logic [15:0]                     bytes_read_r, bytes_read_nxt;
  logic [PIX_W-1:0]                pixels_out_r, pixels_out_nxt;
  logic [7:0]                      low_byte_hold_r, low_byte_hold_nxt;
  logic [15:0]                     colored_left_r, colored_left_nxt;
  logic [23:0]                     pixel_bytes_r, pixel_bytes_nxt;
  logic [1:0]                      pixel_byte_pos_r, pixel_byte_pos_nxt;

  srd_pkg::out_item_t              q_r [srd_pkg::OQ_DEPTH];
  logic [srd_pkg::OQ_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [srd_pkg::OQ_CNT_W-1:0]    count_r;

  // Decode signals
  logic                  in_fire, out_fire, rs;
  logic [7:0]            b;
  srd_pkg::phase_t       eff_phase;
  logic [1:0]            hc_inc;
  logic [15:0]           size_val, br_hdr, rem_hdr, br_pix, nr_br, nr_pay, nr_left;
  logic [16:0]           br_sum;
  logic [17:0]           c_bytes;
  logic [2:0]            bpp;
  logic [CS_W-1:0]       side_eff;
  logic [2*CS_W-1:0]     cap_full;
  logic [PIX_W-1:0]      cap, room_a, room_b, p_after, p_plus1, p_b;
  logic                  skip_ovf, col_ovf, data_short, nr_end, pix_emit, last_pix;
  logic [2:0]            nr_status;
  logic [23:0]           pb_upd;

  srd_pkg::out_item_t    res0, res1;
  logic [1:0]            res_n;

  function automatic logic [PIX_W-1:0] room_of(input logic [PIX_W-1:0] p,
                                               input logic [PIX_W-1:0] c);
    return (p >= c) ? '0 : c - p;
  endfunction

  function automatic srd_pkg::out_item_t blank_item();
    srd_pkg::out_item_t it;
    it = '0;
    return it;
  endfunction

  function automatic srd_pkg::out_item_t end_item(input logic [2:0] st,
                                                  input logic [PIX_W-1:0] p);
    srd_pkg::out_item_t it;
    it             = '0;
    it.kind        = srd_pkg::KIND_END;
    it.pixel_index = srd_pkg::IDX_W'(p);
    it.status      = st;
    it.last        = 1'b1;
    return it;
  endfunction

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;
  assign rs       = in_data.record_start;
  assign b        = in_data.data_byte;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_alpha_r   <= 1'b0;
      sprite_side_r <= srd_pkg::SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srd_pkg::CFG_USE_ALPHA:   use_alpha_r   <= cfg_wdata[0];
        srd_pkg::CFG_SPRITE_SIDE: sprite_side_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capacity: clamped side squared
  always_comb begin
    side_eff = CS_W'(sprite_side_r);
    if (side_eff == '0) side_eff = CS_W'(1);
    if (side_eff > CS_W'(MAX_SIDE)) side_eff = CS_W'(MAX_SIDE);
    cap_full = side_eff * side_eff;
    cap      = PIX_W'(cap_full);
  end

  // Byte decode: run checks and end-of-record decision
  always_comb begin
    eff_phase = rs ? srd_pkg::PH_KEY : phase_r;
    hc_inc    = (rs ? 2'd0 : header_count_r) + 2'd1;
    size_val  = {b, low_byte_hold_r};
    bpp       = use_alpha_r ? 3'd4 : 3'd3;

    // run header checks
    br_hdr     = bytes_read_r + 16'd4;
    room_a     = room_of(pixels_out_r, cap);
    skip_ovf   = CMP_W'(colored_left_r) > CMP_W'(room_a);
    p_after    = pixels_out_r + PIX_W'(colored_left_r);
    rem_hdr    = payload_size_r - br_hdr;
    c_bytes    = use_alpha_r ? {size_val, 2'b00}
                             : ({2'b00, size_val} + {1'b0, size_val, 1'b0});
    data_short = c_bytes > {2'b00, rem_hdr};

    // pixel byte handling
    pix_emit = ({1'b0, pixel_byte_pos_r} + 3'd1) >= bpp;
    last_pix = colored_left_r == 16'd1;
    p_plus1  = pixels_out_r + PIX_W'(1);
    br_sum   = {1'b0, bytes_read_r} + 17'(bpp);
    br_pix   = br_sum[16] ? 16'hFFFF : br_sum[15:0];
    pb_upd   = pixel_bytes_r;
    case (pixel_byte_pos_r)
      2'd0:    pb_upd[7:0]   = b;
      2'd1:    pb_upd[15:8]  = b;
      2'd2:    pb_upd[23:16] = b;
      default: ;
    endcase

    // shared room and next-run unit
    unique case (eff_phase)
      srd_pkg::PH_SIZE_HI: begin
        p_b    = '0;
        nr_br  = 16'd0;
        nr_pay = size_val;
      end
      srd_pkg::PH_C_HI: begin
        p_b    = p_after;
        nr_br  = br_hdr;
        nr_pay = payload_size_r;
      end
      default: begin
        p_b    = p_plus1;
        nr_br  = br_pix;
        nr_pay = payload_size_r;
      end
    endcase
    room_b  = room_of(p_b, cap);
    col_ovf = CMP_W'(size_val) > CMP_W'(room_b);
    nr_left = nr_pay - nr_br;
    if (nr_br >= nr_pay) begin
      nr_end    = 1'b1;
      nr_status = srd_pkg::ST_COMPLETE;
    end else if (room_b == '0) begin
      nr_end    = 1'b1;
      nr_status = srd_pkg::ST_CAP_FULL;
    end else if (nr_left < 16'd4) begin
      nr_end    = 1'b1;
      nr_status = srd_pkg::ST_SHORT_HDR;
    end else begin
      nr_end    = 1'b0;
      nr_status = srd_pkg::ST_COMPLETE;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      unique case (eff_phase)
        srd_pkg::PH_DONE:    phase_nxt = srd_pkg::PH_DONE;
        srd_pkg::PH_KEY:     phase_nxt = (hc_inc == 2'd3) ? srd_pkg::PH_SIZE_LO
                                                          : srd_pkg::PH_KEY;
        srd_pkg::PH_SIZE_LO: phase_nxt = srd_pkg::PH_SIZE_HI;
        srd_pkg::PH_SIZE_HI: phase_nxt = nr_end ? srd_pkg::PH_DONE : srd_pkg::PH_T_LO;
        srd_pkg::PH_T_LO:    phase_nxt = srd_pkg::PH_T_HI;
        srd_pkg::PH_T_HI:    phase_nxt = srd_pkg::PH_C_LO;
        srd_pkg::PH_C_LO:    phase_nxt = srd_pkg::PH_C_HI;
        srd_pkg::PH_C_HI: begin
          if (skip_ovf || col_ovf || data_short) phase_nxt = srd_pkg::PH_DONE;
          else if (size_val == 16'd0)
            phase_nxt = nr_end ? srd_pkg::PH_DONE : srd_pkg::PH_T_LO;
          else phase_nxt = srd_pkg::PH_PIX;
        end
        srd_pkg::PH_PIX: begin
          if (pix_emit && last_pix)
            phase_nxt = nr_end ? srd_pkg::PH_DONE : srd_pkg::PH_T_LO;
        end
        default: phase_nxt = srd_pkg::PH_DONE;
      endcase
    end
  end

  // Counters and results
  always_comb begin
    header_count_nxt   = header_count_r;
    payload_size_nxt   = payload_size_r;
    bytes_read_nxt     = bytes_read_r;
    pixels_out_nxt     = pixels_out_r;
    low_byte_hold_nxt  = low_byte_hold_r;
    colored_left_nxt   = colored_left_r;
    pixel_bytes_nxt    = pixel_bytes_r;
    pixel_byte_pos_nxt = pixel_byte_pos_r;
    res0  = blank_item();
    res1  = blank_item();
    res_n = 2'd0;
    if (in_fire) begin
      // new record: close an open one, then clear the counters
      if (rs) begin
        if (phase_r != srd_pkg::PH_DONE) begin
          res0  = end_item(srd_pkg::ST_DATA_SHORT, pixels_out_r);
          res_n = 2'd1;
        end
        payload_size_nxt   = '0;
        bytes_read_nxt     = '0;
        pixels_out_nxt     = '0;
        low_byte_hold_nxt  = '0;
        colored_left_nxt   = '0;
        pixel_bytes_nxt    = '0;
        pixel_byte_pos_nxt = '0;
      end
      case (eff_phase) inside
        srd_pkg::PH_KEY: header_count_nxt = hc_inc;
        srd_pkg::PH_SIZE_LO, srd_pkg::PH_T_LO, srd_pkg::PH_C_LO: low_byte_hold_nxt = b;
        srd_pkg::PH_SIZE_HI: begin
          payload_size_nxt = size_val;
          bytes_read_nxt   = '0;
          pixels_out_nxt   = '0;
          if (nr_end) begin
            res0  = end_item(nr_status, '0);
            res_n = 2'd1;
          end
        end
        // transparent count parks in colored_left until the colored count arrives
        srd_pkg::PH_T_HI: colored_left_nxt = size_val;
        srd_pkg::PH_C_HI: begin
          bytes_read_nxt = br_hdr;
          if (skip_ovf) begin
            res0  = end_item(srd_pkg::ST_SKIP_OVF, pixels_out_r);
            res_n = 2'd1;
          end else begin
            pixels_out_nxt    = p_after;
            res0.kind         = srd_pkg::KIND_SKIP;
            res0.pixel_index  = srd_pkg::IDX_W'(pixels_out_r);
            res0.skip_count   = colored_left_r;
            res_n             = 2'd1;
            if (col_ovf) begin
              res1  = end_item(srd_pkg::ST_COLOR_OVF, p_after);
              res_n = 2'd2;
            end else if (data_short) begin
              res1  = end_item(srd_pkg::ST_DATA_SHORT, p_after);
              res_n = 2'd2;
            end else if (size_val == 16'd0) begin
              if (nr_end) begin
                res1  = end_item(nr_status, p_after);
                res_n = 2'd2;
              end
            end else begin
              colored_left_nxt   = size_val;
              pixel_bytes_nxt    = '0;
              pixel_byte_pos_nxt = '0;
            end
          end
        end
        srd_pkg::PH_PIX: begin
          if (pix_emit) begin
            res0.kind          = srd_pkg::KIND_PIXEL;
            res0.pixel_index   = srd_pkg::IDX_W'(pixels_out_r);
            res0.red           = pb_upd[7:0];
            res0.green         = pb_upd[15:8];
            res0.blue          = pb_upd[23:16];
            res0.alpha         = use_alpha_r ? b : 8'hFF;
            res_n              = 2'd1;
            pixel_bytes_nxt    = '0;
            pixel_byte_pos_nxt = '0;
            bytes_read_nxt     = br_pix;
            pixels_out_nxt     = p_plus1;
            colored_left_nxt   = colored_left_r - 16'd1;
            if (last_pix && nr_end) begin
              res1  = end_item(nr_status, p_plus1);
              res_n = 2'd2;
            end
          end else begin
            pixel_bytes_nxt    = pb_upd;
            pixel_byte_pos_nxt = pixel_byte_pos_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= srd_pkg::PH_DONE;
      header_count_r   <= '0;
      payload_size_r   <= '0;
      bytes_read_r     <= '0;
      pixels_out_r     <= '0;
      low_byte_hold_r  <= '0;
      colored_left_r   <= '0;
      pixel_bytes_r    <= '0;
      pixel_byte_pos_r <= '0;
    end else begin
      phase_r          <= phase_nxt;
      header_count_r   <= header_count_nxt;
      payload_size_r   <= payload_size_nxt;
      bytes_read_r     <= bytes_read_nxt;
      pixels_out_r     <= pixels_out_nxt;
      low_byte_hold_r  <= low_byte_hold_nxt;
      colored_left_r   <= colored_left_nxt;
      pixel_bytes_r    <= pixel_bytes_nxt;
      pixel_byte_pos_r <= pixel_byte_pos_nxt;
    end
  end

  // Result queue: up to two writes, one read per cycle
  assign in_ready  = count_r <= srd_pkg::OQ_CNT_W'(srd_pkg::OQ_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (res_n != 2'd0) q_r[wr_ptr_r] <= res0;
    if (res_n == 2'd2) q_r[wr_ptr_r + srd_pkg::OQ_PTR_W'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + srd_pkg::OQ_PTR_W'(res_n);
      if (out_fire) rd_ptr_r <= rd_ptr_r + srd_pkg::OQ_PTR_W'(1);
      count_r  <= count_r + srd_pkg::OQ_CNT_W'(res_n) - srd_pkg::OQ_CNT_W'(out_fire);
    end
  end

  // Checks
  `SRD_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1,
                  count_r <= srd_pkg::OQ_CNT_W'(srd_pkg::OQ_DEPTH))
  `SRD_ASSERT_NEXT(a_start_key, clk, rst_n, in_fire && rs, phase_r == srd_pkg::PH_KEY)
  `SRD_ASSERT_NEXT(a_pix_exit, clk, rst_n,
                   in_fire && !rs && phase_r == srd_pkg::PH_PIX,
                   phase_r == srd_pkg::PH_PIX || phase_r == srd_pkg::PH_T_LO ||
                   phase_r == srd_pkg::PH_DONE)

endmodule
